// ===== hw/rtl/lmm_pkg.sv =====
`default_nettype none

package lmm_pkg;

  localparam int PixW            = 8;
  localparam int ColW            = 11;
  localparam int RowW            = 16;
  localparam int CfgW            = 16;
  localparam int CfgIdxW         = 2;
  localparam int ImgWidthRegW    = 12;
  localparam int MaxWidthDefault = 2048;

  localparam logic [PixW-1:0]         ThresholdReset = '0;
  localparam int                      WidthReset     = 2048;
  localparam logic [RowW-1:0]         HeightReset    = 16'd480;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int FifoCntW  = FifoAw + 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgWidth     = 2'd1,
    CfgHeight    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic            mask_bit;
    logic [ColW-1:0] center_col;
    logic [RowW-1:0] center_row;
    logic            last;
  } mask_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lmm_pix_if.sv =====
`default_nettype none

interface lmm_pix_if;
  logic                     valid;
  logic                     ready;
  logic [lmm_pkg::PixW-1:0] pixel;
  logic                     start_of_frame;

  modport source (output valid, pixel, start_of_frame, input ready);
  modport sink (input valid, pixel, start_of_frame, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lmm_mask_if.sv =====
`default_nettype none

interface lmm_mask_if;
  logic                     valid;
  logic                     ready;
  logic                     mask_bit;
  logic [lmm_pkg::ColW-1:0] center_col;
  logic [lmm_pkg::RowW-1:0] center_row;
  logic                     last;

  modport source (output valid, mask_bit, center_col, center_row, last, input ready);
  modport sink (input valid, mask_bit, center_col, center_row, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lmm_line_store.sv =====
`default_nettype none

module lmm_line_store #(
  parameter int MAX_WIDTH = lmm_pkg::MaxWidthDefault,
  parameter int AddrW     = $clog2(MAX_WIDTH)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [AddrW-1:0]         rd_addr_i,
  input  wire logic                     wr_en_i,
  input  wire logic [AddrW-1:0]         wr_addr_i,
  input  wire logic [lmm_pkg::PixW-1:0] wr_pix_i,
  output logic      [lmm_pkg::PixW-1:0] up2_o,
  output logic      [lmm_pkg::PixW-1:0] up1_o
);

  logic [lmm_pkg::PixW-1:0] mem_older_q [MAX_WIDTH];
  logic [lmm_pkg::PixW-1:0] mem_newer_q [MAX_WIDTH];
  logic [lmm_pkg::PixW-1:0] rd_older_q, rd_newer_q;
  logic [lmm_pkg::PixW-1:0] fwd_up2_q, fwd_up1_q;
  logic                     fwd_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_older_q <= mem_older_q[rd_addr_i];
      rd_newer_q <= mem_newer_q[rd_addr_i];
    end
  end

  // read-modify-write: older takes what newer held, newer takes the item
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_older_q[wr_addr_i] <= up1_o;
      mem_newer_q[wr_addr_i] <= wr_pix_i;
    end
  end

  // same entry read while its write is still in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= rd_en_i && wr_en_i && (rd_addr_i == wr_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_up2_q <= up1_o;
    fwd_up1_q <= wr_pix_i;
  end

  assign up2_o = fwd_q ? fwd_up2_q : rd_older_q;
  assign up1_o = fwd_q ? fwd_up1_q : rd_newer_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lmm_window.sv =====
`default_nettype none

module lmm_window (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     shift_i,
  input  wire logic [lmm_pkg::PixW-1:0] up2_i,
  input  wire logic [lmm_pkg::PixW-1:0] up1_i,
  input  wire logic [lmm_pkg::PixW-1:0] pix_i,
  input  wire logic [lmm_pkg::PixW-1:0] threshold_i,
  output logic                          mask_bit_o
);

  // rows top to bottom; [0] is the left column, [1] the middle column
  logic [lmm_pkg::PixW-1:0] win_q [3][2];
  logic [lmm_pkg::PixW-1:0] ctr;
  logic horiz, vert, diag_main, diag_anti;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= '0;
        win_q[i][1] <= '0;
      end
    end else if (shift_i) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
      end
      win_q[0][1] <= up2_i;
      win_q[1][1] <= up1_i;
      win_q[2][1] <= pix_i;
    end
  end

  // window of the registered columns plus the incoming right column, centred on the middle column's middle
  always_comb begin
    ctr        = win_q[1][1];
    horiz      = (ctr > win_q[1][0]) && (ctr > up1_i);
    vert       = (ctr > win_q[0][1]) && (ctr > win_q[2][1]);
    diag_main  = (ctr > win_q[0][0]) && (ctr > pix_i);
    diag_anti  = (ctr > up2_i) && (ctr > win_q[2][0]);
    mask_bit_o = (ctr > threshold_i) && (horiz || vert || diag_main || diag_anti);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lmm_out_fifo.sv =====
`default_nettype none

module lmm_out_fifo (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire lmm_pkg::mask_item_t          item_i,
  output logic      [lmm_pkg::FifoCntW-1:0] cnt_o,
  lmm_mask_if.source                        out_o
);

  lmm_pkg::mask_item_t              mem_q [lmm_pkg::FifoDepth];
  logic [lmm_pkg::FifoAw-1:0]       wptr_q, rptr_q;
  logic [lmm_pkg::FifoCntW-1:0]     cnt_q;
  logic                             pop;
  lmm_pkg::mask_item_t              head;

  assign pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + lmm_pkg::FifoAw'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + lmm_pkg::FifoAw'(1);
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + lmm_pkg::FifoCntW'(1);
        2'b01:   cnt_q <= cnt_q - lmm_pkg::FifoCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head             = mem_q[rptr_q];
  assign out_o.valid      = (cnt_q != '0);
  assign out_o.mask_bit   = head.mask_bit;
  assign out_o.center_col = head.center_col;
  assign out_o.center_row = head.center_row;
  assign out_o.last       = head.last;
  assign cnt_o            = cnt_q;

endmodule

`default_nettype wire

// ===== hw/rtl/local_maximum_mask_3x3_unit.sv =====
// a result passes the s1 stage registers and is written into the output fifo before it is presented
// throughput: one pixel per cycle while the output fifo has room, bounded by the read-modify-write of the line stores
// output items queue in a four-entry fifo; input stalls only when it could overflow
// reset: counters zero, threshold 0, width 2048 (clamped to MAX_WIDTH), height 480
// reset: window cleared, line stores keep contents and need no clearing pass
`default_nettype none

module local_maximum_mask_3x3_unit #(
  parameter int MAX_WIDTH = lmm_pkg::MaxWidthDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lmm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [lmm_pkg::CfgW-1:0]    cfg_wdata_i,
  lmm_pix_if.sink                          pix_i,
  lmm_mask_if.source                       mask_o
);

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int RowW     = lmm_pkg::RowW;
  localparam int PixW     = lmm_pkg::PixW;
  localparam int ResetW   = (lmm_pkg::WidthReset > MAX_WIDTH) ? MAX_WIDTH : lmm_pkg::WidthReset;
  localparam logic [CW-1:0] WLastMax   = CW'(MAX_WIDTH - 1);
  localparam logic [CW-1:0] WLastReset = CW'(ResetW - 1);
  localparam logic [CW-1:0] WLastMin   = CW'(2);

  logic [PixW-1:0] thr_q;
  logic [CW-1:0]   w_last_q, w_last_d;
  logic [RowW-1:0] h_last_q, h_last_d;
  logic [31:0]     w_req;

  logic [CW-1:0]   col_q, col_d, c_cur;
  logic [RowW-1:0] row_q, row_d, r_cur;
  logic            in_acc, emit, last;

  logic            s1_valid_q, s1_emit_q, s1_last_q;
  logic [CW-1:0]   s1_col_q;
  logic [RowW-1:0] s1_row_q;
  logic [PixW-1:0] s1_pix_q;

  logic [PixW-1:0] up2, up1;
  logic            mask_bit, push;
  logic [lmm_pkg::FifoCntW-1:0] fifo_cnt;
  lmm_pkg::mask_item_t          item;

  // configuration, clamped at write time
  always_comb begin
    w_req = 32'(cfg_wdata_i[lmm_pkg::ImgWidthRegW-1:0]);
    if (w_req < 32'd3) begin
      w_last_d = WLastMin;
    end else if (w_req > 32'(MAX_WIDTH)) begin
      w_last_d = WLastMax;
    end else begin
      w_last_d = CW'(w_req - 32'd1);
    end
    if (cfg_wdata_i < lmm_pkg::CfgW'(3)) begin
      h_last_d = RowW'(2);
    end else begin
      h_last_d = RowW'(cfg_wdata_i - lmm_pkg::CfgW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= lmm_pkg::ThresholdReset;
      w_last_q <= WLastReset;
      h_last_q <= lmm_pkg::HeightReset - RowW'(1);
    end else if (cfg_we_i) begin
      unique case (lmm_pkg::cfg_reg_e'(cfg_idx_i))
        lmm_pkg::CfgThreshold: thr_q    <= cfg_wdata_i[PixW-1:0];
        lmm_pkg::CfgWidth:     w_last_q <= w_last_d;
        lmm_pkg::CfgHeight:    h_last_q <= h_last_d;
        default: ;
      endcase
    end
  end

  // position counting
  assign in_acc = pix_i.valid && pix_i.ready;

  always_comb begin
    c_cur = pix_i.start_of_frame ? '0 : col_q;
    r_cur = pix_i.start_of_frame ? '0 : row_q;
    emit  = (r_cur >= RowW'(2)) && (r_cur <= h_last_q) &&
            (c_cur >= CW'(2)) && (c_cur <= w_last_q);
    last  = (r_cur == h_last_q) && (c_cur == w_last_q);
    if (c_cur >= w_last_q) begin
      col_d = '0;
      row_d = (r_cur >= h_last_q) ? '0 : r_cur + RowW'(1);
    end else begin
      col_d = c_cur + CW'(1);
      row_d = r_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      if (in_acc) begin
        col_q     <= col_d;
        row_q     <= row_d;
        s1_emit_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q  <= c_cur;
      s1_row_q  <= r_cur;
      s1_last_q <= last;
      s1_pix_q  <= pix_i.pixel;
    end
  end

  // room for the item in flight and the one being accepted
  assign push        = s1_valid_q && s1_emit_q;
  assign pix_i.ready = (({1'b0, fifo_cnt}) + (lmm_pkg::FifoCntW + 1)'(push))
                       < (lmm_pkg::FifoCntW + 1)'(lmm_pkg::FifoDepth);

  lmm_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .AddrW     (CW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (c_cur),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_pix_i  (s1_pix_q),
    .up2_o     (up2),
    .up1_o     (up1)
  );

  lmm_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (s1_valid_q),
    .up2_i       (up2),
    .up1_i       (up1),
    .pix_i       (s1_pix_q),
    .threshold_i (thr_q),
    .mask_bit_o  (mask_bit)
  );

  always_comb begin
    item.mask_bit   = mask_bit;
    item.center_col = lmm_pkg::ColW'(s1_col_q - CW'(1));
    item.center_row = s1_row_q - RowW'(1);
    item.last       = s1_last_q;
  end

  lmm_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .cnt_o  (fifo_cnt),
    .out_o  (mask_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !(mask_o.valid && mask_o.ready) |-> fifo_cnt < lmm_pkg::FifoCntW'(lmm_pkg::FifoDepth))
    else $error("output fifo overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && pix_i.start_of_frame |=> s1_col_q == '0 && s1_row_q == '0)
    else $error("start of frame did not restart position");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> s1_col_q >= CW'(2) && s1_row_q >= RowW'(2))
    else $error("result pushed for a border pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && s1_last_q |-> s1_row_q == h_last_q && s1_col_q == w_last_q)
    else $error("last flag away from the final interior pixel");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int                 PixW         = lmm_pkg::PixW;
  localparam int                 ColW         = lmm_pkg::ColW;
  localparam int                 RowW         = lmm_pkg::RowW;
  localparam int                 CfgW         = lmm_pkg::CfgW;
  localparam int                 CfgIdxW      = lmm_pkg::CfgIdxW;
  localparam int                 ImgWidthRegW = lmm_pkg::ImgWidthRegW;
  localparam int                 MaxW         = lmm_pkg::MaxWidthDefault;
  localparam logic [CfgIdxW-1:0] CfgSpare     = 2'd3;
  localparam int                 SettleCycles = 6;
  localparam int                 DrainLimit   = 5000;

  class mask_scoreboard;
    logic [PixW-1:0]         older_line [MaxW];
    logic [PixW-1:0]         newer_line [MaxW];
    logic [PixW-1:0]         win [3][3];
    logic [ColW-1:0]         col_cnt;
    logic [RowW-1:0]         row_cnt;
    logic [PixW-1:0]         threshold;
    logic [ImgWidthRegW-1:0] width_reg;
    logic [RowW-1:0]         height_reg;
    lmm_pkg::mask_item_t     expected_masks [$];
    int                      errors;
    int                      checked;
    int                      marked;

    function new();
      foreach (older_line[i]) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_cnt    = '0;
      row_cnt    = '0;
      threshold  = lmm_pkg::ThresholdReset;
      width_reg  = ImgWidthRegW'(lmm_pkg::WidthReset);
      height_reg = lmm_pkg::HeightReset;
      errors     = 0;
      checked    = 0;
      marked     = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    function int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > MaxW) return MaxW;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function int pending();
      return expected_masks.size();
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        lmm_pkg::CfgThreshold: threshold = data[PixW-1:0];
        lmm_pkg::CfgWidth:     width_reg = data[ImgWidthRegW-1:0];
        lmm_pkg::CfgHeight:    height_reg = data[RowW-1:0];
        default: ;
      endcase
    endfunction

    function bit beats(logic [PixW-1:0] v, logic [PixW-1:0] a, logic [PixW-1:0] b);
      return (v > a) && (v > b);
    endfunction

    function void take_pixel(logic [PixW-1:0] px, logic sof);
      int unsigned         w;
      int unsigned         h;
      int unsigned         c;
      int unsigned         r;
      logic [PixW-1:0]     up2;
      logic [PixW-1:0]     up1;
      logic [PixW-1:0]     v;
      lmm_pkg::mask_item_t e;
      w = eff_width();
      h = eff_height();
      if (sof) begin
        col_cnt = '0;
        row_cnt = '0;
      end
      c = col_cnt;
      r = row_cnt;
      up2 = older_line[c];
      up1 = newer_line[c];
      older_line[c] = up1;
      newer_line[c] = px;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = px;
      if (r >= 2 && r < h && c >= 2 && c < w) begin
        v = win[1][1];
        e.mask_bit   = (v > threshold) &&
                       (beats(v, win[1][0], win[1][2]) || beats(v, win[0][1], win[2][1]) ||
                        beats(v, win[0][0], win[2][2]) || beats(v, win[0][2], win[2][0]));
        e.center_col = ColW'(c - 1);
        e.center_row = RowW'(r - 1);
        e.last       = (r == h - 1) && (c == w - 1);
        expected_masks.push_back(e);
      end
      if (c + 1 >= w) begin
        col_cnt = '0;
        row_cnt = (r + 1 >= h) ? '0 : RowW'(r + 1);
      end else begin
        col_cnt = ColW'(c + 1);
      end
    endfunction

    task check_mask(lmm_pkg::mask_item_t got);
      lmm_pkg::mask_item_t want;
      if (expected_masks.size() == 0) begin
        report($sformatf("unexpected mask item at row %0d col %0d",
                         got.center_row, got.center_col));
        return;
      end
      want = expected_masks.pop_front();
      checked++;
      if (want.mask_bit) marked++;
      if (got.mask_bit !== want.mask_bit)
        report($sformatf("mask_bit at row %0d col %0d: got %0b, expected %0b",
                         want.center_row, want.center_col, got.mask_bit, want.mask_bit));
      if (got.center_col !== want.center_col)
        report($sformatf("center_col: got %0d, expected %0d", got.center_col,
                         want.center_col));
      if (got.center_row !== want.center_row)
        report($sformatf("center_row: got %0d, expected %0d", got.center_row,
                         want.center_row));
      if (got.last !== want.last)
        report($sformatf("last at row %0d col %0d: got %0b, expected %0b",
                         want.center_row, want.center_col, got.last, want.last));
    endtask

    task drop_pending();
      if (expected_masks.size() != 0) begin
        report($sformatf("%0d expected mask items never arrived", expected_masks.size()));
        expected_masks.delete();
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  lmm_pix_if  pix_if ();
  lmm_mask_if mask_if ();

  mask_scoreboard mask_sb;

  int pixels_sent    = 0;
  int frames_started = 0;
  int reg_writes     = 0;
  int burst_left     = 0;
  int rx_left        = 0;
  int rx_mode        = 0;

  local_maximum_mask_3x3_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_if),
    .mask_o      (mask_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("timeout: stream stopped making progress");
    $display("*** FAILED ***");
    $finish;
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 4);
      rx_left = $urandom_range(16, 300);
    end
    rx_left--;
    case (rx_mode)
      1: mask_if.ready <= ($urandom_range(0, 3) != 0);
      2: mask_if.ready <= ($urandom_range(0, 3) == 0);
      3: mask_if.ready <= ((rx_left % 18) < 2);
      default: mask_if.ready <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && mask_if.valid === 1'b1 && mask_if.ready === 1'b1)
      mask_sb.check_mask(lmm_pkg::mask_item_t'{mask_if.mask_bit, mask_if.center_col,
                                               mask_if.center_row, mask_if.last});
  end

  function automatic logic [PixW-1:0] pick_pixel(int mode);
    case (mode)
      1: return PixW'($urandom_range(0, 3));
      2: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      3: return ($urandom_range(0, 7) == 0) ? PixW'($urandom_range(128, 255))
                                            : PixW'($urandom_range(0, 40));
      default: return PixW'($urandom);
    endcase
  endfunction

  task send_pixel(input logic [PixW-1:0] px, input logic sof);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    pix_if.valid          <= 1'b1;
    pix_if.pixel          <= px;
    pix_if.start_of_frame <= sof;
    do @(posedge clk_i); while (pix_if.ready !== 1'b1);
    mask_sb.take_pixel(px, sof);
    pixels_sent++;
    if (sof) frames_started++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task send_run(input int count, input bit sof_first, input int mode);
    for (int i = 0; i < count; i++) send_pixel(pick_pixel(mode), sof_first && i == 0);
  endtask

  // one 3x3 frame, first pixel in the top bits
  task send_window(input logic [9*PixW-1:0] pxs);
    for (int i = 0; i < 9; i++) send_pixel(pxs[PixW*(8-i) +: PixW], i == 0);
  endtask

  task write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    mask_sb.set_reg(idx, data);
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task settle();
    int waited;
    pix_if.valid <= 1'b0;
    burst_left = 0;
    waited = 0;
    while (mask_sb.pending() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    mask_sb.drop_pending();
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task reconfigure();
    logic [PixW-1:0] thr;
    logic [CfgW-1:0] wv;
    logic [CfgW-1:0] hv;
    settle();
    if ($urandom_range(0, 1) != 0) begin
      case ($urandom_range(0, 4))
        0: thr = '0;
        1: thr = '1;
        default: thr = PixW'($urandom);
      endcase
      write_reg(lmm_pkg::CfgThreshold, {8'($urandom), thr});
    end
    if ($urandom_range(0, 1) != 0) begin
      case ($urandom_range(0, 9))
        0: wv = 16'($urandom_range(0, 2));
        1: wv = {4'($urandom), 12'($urandom_range(3, 12))};
        default: wv = 16'($urandom_range(3, 12));
      endcase
      write_reg(lmm_pkg::CfgWidth, wv);
    end
    if ($urandom_range(0, 1) != 0) begin
      case ($urandom_range(0, 11))
        0: hv = 16'($urandom_range(0, 2));
        1: hv = 16'hFFFF;
        default: hv = 16'($urandom_range(3, 8));
      endcase
      write_reg(lmm_pkg::CfgHeight, hv);
    end
    if ($urandom_range(0, 15) == 0) write_reg(CfgSpare, 16'($urandom));
  endtask

  initial begin : stimulus
    int          goal;
    int          kind;
    int          mode;
    int unsigned w;
    int unsigned len;
    mask_sb = new();
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = lmm_pkg::CfgThreshold;
    cfg_wdata_i           = '0;
    pix_if.valid          = 1'b0;
    pix_if.pixel          = '0;
    pix_if.start_of_frame = 1'b0;
    mask_if.ready         = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset sizes: part of the first row, no results yet
    send_run(16, 1'b1, 0);
    settle();
    // counter past the new width wraps into row 1; the full rows after it
    // leave both line stores holding known pixels in every column below 12
    write_reg(lmm_pkg::CfgWidth, 16'd12);
    write_reg(lmm_pkg::CfgHeight, 16'd4);
    send_run(34, 1'b0, 0);
    settle();
    // shrink below the current row and column, counters wrap on the next item
    write_reg(lmm_pkg::CfgWidth, 16'd5);
    write_reg(lmm_pkg::CfgHeight, 16'd3);
    send_run(7, 1'b0, 0);
    settle();

    write_reg(lmm_pkg::CfgWidth, 16'd0);
    write_reg(lmm_pkg::CfgHeight, 16'd1);
    write_reg(lmm_pkg::CfgThreshold, 16'hAB00 | 16'd254);
    send_window({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
    settle();
    write_reg(lmm_pkg::CfgThreshold, 16'h00FF);
    write_reg(lmm_pkg::CfgWidth, 16'hF003);
    write_reg(lmm_pkg::CfgHeight, 16'd2);
    send_window({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
    settle();
    // peak along the vertical only
    write_reg(lmm_pkg::CfgThreshold, 16'd0);
    send_window({8'd9, 8'd5, 8'd9, 8'd9, 8'd8, 8'd9, 8'd9, 8'd5, 8'd9});
    settle();

    write_reg(CfgSpare, 16'hFFFF);
    write_reg(lmm_pkg::CfgWidth, 16'd6);
    write_reg(lmm_pkg::CfgHeight, 16'd4);

    goal = pixels_sent + 900;
    while (pixels_sent < goal) begin
      if ($urandom_range(0, 3) == 0) reconfigure();
      mode = $urandom_range(0, 3);
      kind = $urandom_range(0, 9);
      w    = mask_sb.eff_width();
      len  = w * mask_sb.eff_height();
      if (len > w * 8) len = w * $urandom_range(3, 8);
      case (kind)
        0: repeat ($urandom_range(1, 8)) send_pixel(PixW'($urandom), $urandom_range(0, 3) == 0);
        1: send_run($urandom_range(1, len - 1), 1'b1, mode);
        2: send_run(len, 1'b0, mode);
        default: send_run(len, 1'b1, mode);
      endcase
    end
    settle();

    $display("covered %0d pixels over %0d frame starts with %0d register writes",
             pixels_sent, frames_started, reg_writes);
    $display("checked %0d mask items, %0d marked, %0d mismatches",
             mask_sb.checked, mask_sb.marked, mask_sb.errors);
    if (mask_sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lmm_pkg.sv
hw/rtl/lmm_pix_if.sv
hw/rtl/lmm_mask_if.sv
hw/rtl/lmm_line_store.sv
hw/rtl/lmm_window.sv
hw/rtl/lmm_out_fifo.sv
hw/rtl/local_maximum_mask_3x3_unit.sv
tb/tb.sv
